// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the parser's checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A signal keeps its value in the cycle after the condition holds.
`define ASSERT_STABLE(label, clk, rst_n, cond, sig, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
		else $error(msg);

`endif

// ===== design/opsr_pkg.sv =====
// ----------------------------------------------------------------------------
// opsr_pkg
// Types, codes and helper functions of the operator-precedence parser.
// ----------------------------------------------------------------------------
package opsr_pkg;

	localparam int SYM_W       = 3;
	localparam int ACT_W       = 3;
	localparam int DEPTH_W     = 5;
	localparam int CFG_W       = 64;
	localparam int CFG_IDX_W   = 2;
	localparam int REL_W       = 2;
	localparam int REL_TABLE_W = 2 * CFG_W;

	localparam int DEF_STACK_DEPTH  = 16;
	localparam int DEF_SYMBOL_COUNT = 8;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_REL_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REL_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_END_SYM  = 2'd2;

	// Input operation codes.
	localparam logic OP_START  = 1'b0;
	localparam logic OP_SYMBOL = 1'b1;

	typedef enum logic [REL_W-1:0] {
		REL_NONE = 2'd0,
		REL_GT   = 2'd1,
		REL_EQ   = 2'd2,
		REL_LT   = 2'd3
	} rel_t;

	typedef enum logic [ACT_W-1:0] {
		ACT_STARTED   = 3'd0,
		ACT_SHIFTED   = 3'd1,
		ACT_POPPED    = 3'd2,
		ACT_ACCEPTED  = 3'd3,
		ACT_NOREL     = 3'd4,
		ACT_OVERFLOW  = 3'd5,
		ACT_UNDERFLOW = 3'd6,
		ACT_IDLE      = 3'd7
	} act_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_POP,
		ST_UNDER
	} back_state_t;

	typedef enum logic [3:0] {
		STEP_NONE,
		STEP_START,
		STEP_REPLY_IDLE,
		STEP_UNDER,
		STEP_ACCEPT,
		STEP_SHIFT,
		STEP_OVERFLOW,
		STEP_NOREL,
		STEP_POP
	} step_t;

	// One classified input item.
	typedef struct packed {
		logic             start;
		logic [SYM_W-1:0] sym;
		logic             sym_ok;
		logic             sym_end;
	} item_t;

	typedef struct packed {
		logic  push;
		item_t item;
	} queue_wr_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_rd_t;

	function automatic logic sym_in_range(input logic [SYM_W-1:0] s,
		input logic [SYM_W:0] limit);
		return {1'b0, s} < limit;
	endfunction

	// Entry index is incoming * 8 + top, two bits per entry.
	function automatic rel_t rel_lookup(input logic [REL_TABLE_W-1:0] tbl,
		input logic [SYM_W-1:0] incoming, input logic [SYM_W-1:0] top);
		logic [2*SYM_W:0] bit_idx;
		bit_idx = {incoming, top, 1'b0};
		return rel_t'(tbl[bit_idx +: REL_W]);
	endfunction

endpackage

// ===== design/opsr_front.sv =====
// ----------------------------------------------------------------------------
// opsr_front
// Input handshake and classification of each word before it is queued.
// ----------------------------------------------------------------------------
module opsr_front
	import opsr_pkg::*;
#(
	parameter int SYMBOL_COUNT = DEF_SYMBOL_COUNT
) (
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             operation,
	input  logic [SYM_W-1:0] symbol,
	input  logic [SYM_W-1:0] end_symbol,
	input  logic             queue_full,
	output queue_wr_t        wr
);

	localparam logic [SYM_W:0] SYM_LIMIT = (SYM_W + 1)'(SYMBOL_COUNT);

	assign in_ready = !queue_full;

	always_comb begin
		wr.push         = in_valid && !queue_full;
		wr.item.start   = (operation == OP_START);
		wr.item.sym     = symbol;
		wr.item.sym_ok  = sym_in_range(symbol, SYM_LIMIT);
		wr.item.sym_end = (symbol == end_symbol);
	end

endmodule

// ===== design/opsr_queue.sv =====
// ----------------------------------------------------------------------------
// opsr_queue
// Short queue of classified items between the front and the back end.
// ----------------------------------------------------------------------------
module opsr_queue
	import opsr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  queue_wr_t wr,
	output logic      full,
	input  logic      deq,
	output queue_rd_t head
);

	item_t              entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  fill_q;
	logic               do_pop;

	assign full       = (fill_q == QCNT_W'(QUEUE_DEPTH));
	assign head.valid = (fill_q != '0);
	assign head.item  = entries_q[rd_ptr_q];
	assign do_pop     = deq && head.valid;

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (wr.push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (wr.push && !do_pop) begin
				fill_q <= fill_q + QCNT_W'(1);
			end else if (!wr.push && do_pop) begin
				fill_q <= fill_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr.push) begin
			entries_q[wr_ptr_q] <= wr.item;
		end
	end

endmodule

// ===== design/opsr_back.sv =====
// ----------------------------------------------------------------------------
// opsr_back
// Stack sequencer: decides, shifts and pops one step per cycle while the
// result register is free, and drives the registered result channel.
// ----------------------------------------------------------------------------
module opsr_back
	import opsr_pkg::*;
#(
	parameter int STACK_DEPTH  = DEF_STACK_DEPTH,
	parameter int SYMBOL_COUNT = DEF_SYMBOL_COUNT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [REL_TABLE_W-1:0] rel_table,
	input  logic [SYM_W-1:0]       end_symbol,
	input  queue_rd_t              head,
	output logic                   deq,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [ACT_W-1:0]       action,
	output logic [SYM_W-1:0]       result_symbol,
	output logic [DEPTH_W-1:0]     stack_depth,
	output logic                   last
);

	localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W = $clog2(STACK_DEPTH);
	localparam logic [SYM_W:0] SYM_LIMIT = (SYM_W + 1)'(SYMBOL_COUNT);

	back_state_t state_q, state_d;
	step_t       step, decide_step;

	logic             running_q;
	logic [CNT_W-1:0] count_q;
	// The top entry and the one below it live in registers; the rest in memory.
	logic [SYM_W-1:0] top_q;
	logic [SYM_W-1:0] below_q;
	logic [SYM_W-1:0] stack_mem [STACK_DEPTH];
	logic [SYM_W-1:0] sym_q;
	logic             sym_ok_q;
	logic             sym_end_q;

	logic             out_valid_q;
	logic [ACT_W-1:0] action_q;
	logic [SYM_W-1:0] result_symbol_q;
	logic [DEPTH_W-1:0] stack_depth_q;
	logic             last_q;

	logic [SYM_W-1:0] cur_sym;
	logic             cur_ok;
	logic             cur_end;
	rel_t             rel_in;
	rel_t             rel_pop;
	logic             can_emit;
	logic             stack_full;
	logic [CNT_W-1:0] wr_idx;
	logic [CNT_W-1:0] rd_idx;

	act_t             emit_act;
	logic [SYM_W-1:0] emit_sym;
	logic [CNT_W-1:0] emit_depth;
	logic             emit_last;

	assign cur_sym  = (state_q == ST_IDLE) ? head.item.sym     : sym_q;
	assign cur_ok   = (state_q == ST_IDLE) ? head.item.sym_ok  : sym_ok_q;
	assign cur_end  = (state_q == ST_IDLE) ? head.item.sym_end : sym_end_q;

	assign rel_in  = (cur_ok && sym_in_range(top_q, SYM_LIMIT))
		? rel_lookup(rel_table, cur_sym, top_q) : REL_NONE;
	assign rel_pop = (sym_in_range(top_q, SYM_LIMIT) && sym_in_range(below_q, SYM_LIMIT))
		? rel_lookup(rel_table, top_q, below_q) : REL_NONE;

	assign can_emit   = !out_valid_q || out_ready;
	assign stack_full = (count_q >= CNT_W'(STACK_DEPTH));
	assign wr_idx     = count_q - CNT_W'(1);
	assign rd_idx     = count_q - CNT_W'(3);

	// A reduce relation performs its first pop in the same cycle.
	always_comb begin
		if (count_q == '0) begin
			decide_step = STEP_UNDER;
		end else if (cur_end && (top_q == end_symbol)) begin
			decide_step = STEP_ACCEPT;
		end else begin
			unique case (rel_in) inside
				REL_GT, REL_EQ: decide_step = stack_full ? STEP_OVERFLOW : STEP_SHIFT;
				REL_LT:         decide_step = STEP_POP;
				default:        decide_step = STEP_NOREL;
			endcase
		end
	end

	always_comb begin
		step = STEP_NONE;
		if (can_emit) begin
			unique case (state_q)
				ST_IDLE: begin
					if (head.valid) begin
						if (head.item.start) begin
							step = STEP_START;
						end else if (!running_q) begin
							step = STEP_REPLY_IDLE;
						end else begin
							step = decide_step;
						end
					end
				end
				ST_DECIDE: step = decide_step;
				ST_POP:    step = STEP_POP;
				ST_UNDER:  step = STEP_UNDER;
				default:   step = STEP_NONE;
			endcase
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (step)
			STEP_NONE: state_d = state_q;
			STEP_POP: begin
				if (count_q == CNT_W'(1)) begin
					state_d = ST_UNDER;
				end else if (rel_pop == REL_GT) begin
					state_d = ST_DECIDE;
				end else begin
					state_d = ST_POP;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		deq        = (state_q == ST_IDLE) && (step != STEP_NONE);
		emit_act   = ACT_IDLE;
		emit_sym   = '0;
		emit_depth = count_q;
		emit_last  = 1'b1;
		unique case (step)
			STEP_START: begin
				emit_act   = ACT_STARTED;
				emit_depth = CNT_W'(1);
			end
			STEP_REPLY_IDLE: emit_act = ACT_IDLE;
			STEP_UNDER: begin
				emit_act   = ACT_UNDERFLOW;
				emit_depth = '0;
			end
			STEP_ACCEPT:   emit_act = ACT_ACCEPTED;
			STEP_OVERFLOW: emit_act = ACT_OVERFLOW;
			STEP_NOREL:    emit_act = ACT_NOREL;
			STEP_SHIFT: begin
				emit_act   = ACT_SHIFTED;
				emit_sym   = cur_sym;
				emit_depth = count_q + CNT_W'(1);
			end
			STEP_POP: begin
				emit_act   = ACT_POPPED;
				emit_sym   = top_q;
				emit_depth = count_q - CNT_W'(1);
				emit_last  = 1'b0;
			end
			default: emit_last = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			running_q   <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (step != STEP_NONE) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (step) inside
				STEP_START: begin
					running_q <= 1'b1;
					count_q   <= CNT_W'(1);
				end
				STEP_UNDER: begin
					running_q <= 1'b0;
					count_q   <= '0;
				end
				STEP_ACCEPT, STEP_OVERFLOW, STEP_NOREL: running_q <= 1'b0;
				STEP_SHIFT: count_q <= count_q + CNT_W'(1);
				STEP_POP:   count_q <= count_q - CNT_W'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (deq) begin
			sym_q     <= head.item.sym;
			sym_ok_q  <= head.item.sym_ok;
			sym_end_q <= head.item.sym_end;
		end
		case (step) inside
			STEP_START: top_q <= end_symbol;
			STEP_SHIFT: begin
				stack_mem[wr_idx[ADDR_W-1:0]] <= top_q;
				below_q <= top_q;
				top_q   <= cur_sym;
			end
			STEP_POP: begin
				top_q   <= below_q;
				below_q <= stack_mem[rd_idx[ADDR_W-1:0]];
			end
			default: ;
		endcase
		if (step != STEP_NONE) begin
			action_q        <= emit_act;
			result_symbol_q <= emit_sym;
			stack_depth_q   <= DEPTH_W'(emit_depth);
			last_q          <= emit_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign action        = action_q;
	assign result_symbol = result_symbol_q;
	assign stack_depth   = stack_depth_q;
	assign last          = last_q;

endmodule

// ===== design/operator_precedence_shift_reduce_top.sv =====
// ----------------------------------------------------------------------------
// operator_precedence_shift_reduce_top
// Operator-precedence shift-reduce parser over 3-bit symbol indices. Input
// words enter a two-entry queue on the edge they are accepted, so up to two
// items can wait while the back end works. The back end produces one result
// word per cycle whenever the output register is free: start, shift, accept
// and every error yield one result word, and a reduction yields one more
// word for each symbol popped (plus the underflow word if the stack empties).
// The stack memory sees at most one push or pop per result word. The stack
// needs no clearing after reset; configuration is taken at any time on the
// configuration channel, which is always ready.
// ----------------------------------------------------------------------------
module operator_precedence_shift_reduce_top
	import opsr_pkg::*;
#(
	parameter int STACK_DEPTH  = DEF_STACK_DEPTH,
	parameter int SYMBOL_COUNT = DEF_SYMBOL_COUNT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 operation,
	input  logic [SYM_W-1:0]     symbol,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [ACT_W-1:0]     action,
	output logic [SYM_W-1:0]     result_symbol,
	output logic [DEPTH_W-1:0]   stack_depth,
	output logic                 last,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic [CFG_W-1:0] rel_low_q;
	logic [CFG_W-1:0] rel_high_q;
	logic [SYM_W-1:0] end_sym_q;

	queue_wr_t q_wr;
	queue_rd_t q_head;
	logic      q_full;
	logic      q_deq;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rel_low_q  <= '0;
			rel_high_q <= '0;
			end_sym_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_REL_LOW:  rel_low_q  <= cfg_data;
				CFG_REL_HIGH: rel_high_q <= cfg_data;
				CFG_END_SYM:  end_sym_q  <= cfg_data[SYM_W-1:0];
				default: ;
			endcase
		end
	end

	opsr_front #(
		.SYMBOL_COUNT(SYMBOL_COUNT)
	) u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.symbol    (symbol),
		.end_symbol(end_sym_q),
		.queue_full(q_full),
		.wr        (q_wr)
	);

	opsr_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (q_wr),
		.full  (q_full),
		.deq   (q_deq),
		.head  (q_head)
	);

	opsr_back #(
		.STACK_DEPTH (STACK_DEPTH),
		.SYMBOL_COUNT(SYMBOL_COUNT)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.rel_table    ({rel_high_q, rel_low_q}),
		.end_symbol   (end_sym_q),
		.head         (q_head),
		.deq          (q_deq),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.action       (action),
		.result_symbol(result_symbol),
		.stack_depth  (stack_depth),
		.last         (last)
	);

endmodule

// ===== design/opsr_checker.sv =====
// ----------------------------------------------------------------------------
// opsr_checker
// Port-level checks on the result channel of the parser, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module opsr_checker
	import opsr_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic [ACT_W-1:0]   action,
	input logic [SYM_W-1:0]   result_symbol,
	input logic [DEPTH_W-1:0] stack_depth,
	input logic               last
);

	`ASSERT_PROP(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(action), "result word dropped or changed while stalled")
	`ASSERT_STABLE(a_sym_hold, clk, arst_n, out_valid && !out_ready, result_symbol, "result symbol changed while stalled")

	// A pop is always followed by another word of the same item.
	`ASSERT_PROP(a_pop_not_last, clk, arst_n, out_valid && (action == ACT_POPPED) |-> !last, "popped word marked last")
	`ASSERT_PROP(a_final_last, clk, arst_n, out_valid && (action != ACT_POPPED) |-> last, "final word of an item not marked last")
	`ASSERT_PROP(a_depth_codes, clk, arst_n, out_valid && ((action == ACT_UNDERFLOW && stack_depth != '0) || (action == ACT_STARTED && stack_depth != DEPTH_W'(1))) |-> 1'b0, "wrong depth on start or underflow")

endmodule

bind operator_precedence_shift_reduce_top opsr_checker u_opsr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.action       (action),
	.result_symbol(result_symbol),
	.stack_depth  (stack_depth),
	.last         (last)
);
